[design/assert_macros.svh]
// Assertion macros for the design files; the top-level unit includes them.
// LSX_ASSERT expects a clock named clk and an active-low reset named arst_n in scope; LSX_ASSERT_ALWAYS needs only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while the block is out of reset.
`define LSX_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// Checked at every edge, reset included.
`define LSX_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define LSX_ASSERT(label, prop)
`define LSX_ASSERT_ALWAYS(label, prop)
`endif
`endif

[design/lsx_pkg.sv]
`timescale 1ns / 1ps
package lsx_pkg;

	localparam int OP_W        = 5;
	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 64;

	// Operation codes of the instruction set handled here. Codes above OP_TYA are no-ops.
	typedef enum logic [OP_W-1:0] {
		OP_DEC = 5'd0,
		OP_DEX = 5'd1,
		OP_DEY = 5'd2,
		OP_INC = 5'd3,
		OP_INX = 5'd4,
		OP_INY = 5'd5,
		OP_LDA = 5'd6,
		OP_LDX = 5'd7,
		OP_LDY = 5'd8,
		OP_STA = 5'd9,
		OP_STX = 5'd10,
		OP_STY = 5'd11,
		OP_TAX = 5'd12,
		OP_TAY = 5'd13,
		OP_TSX = 5'd14,
		OP_TXA = 5'd15,
		OP_TXS = 5'd16,
		OP_TYA = 5'd17
	} op_t;

	typedef enum logic [2:0] {
		SRC_MEM,
		SRC_ACC,
		SRC_X,
		SRC_Y,
		SRC_SP
	} src_t;

	typedef enum logic [1:0] {
		ADJ_NONE,
		ADJ_INC,
		ADJ_DEC
	} adj_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_MEM,
		DST_ACC,
		DST_X,
		DST_Y,
		DST_SP
	} dst_t;

	// Classified instruction as it travels from the front end to the back end.
	typedef struct packed {
		src_t              src;
		adj_t              adj;
		dst_t              dst;
		logic              set_nz;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] rd;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wd;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] sp;
		logic              z;
		logic              n;
	} res_t;

endpackage

[design/lsx_fifo.sv]
`timescale 1ns / 1ps
module lsx_fifo import lsx_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head_cmd,
	output fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[design/lsx_front.sv]
`timescale 1ns / 1ps
module lsx_front import lsx_pkg::*; (
	input  logic                  tvalid,
	output logic                  tready,
	input  logic [IN_TDATA_W-1:0] tdata,
	input  fifo_stat_t            q_stat,
	output logic                  push,
	output cmd_t                  cmd
);

	op_t op;

	assign op     = op_t'(tdata[OP_W-1:0]);
	assign tready = !q_stat.full;
	assign push   = tvalid && !q_stat.full;

	// Each instruction reduces to: pick a source, optionally step it by one,
	// and send it to one destination.
	always_comb begin
		cmd.src    = SRC_MEM;
		cmd.adj    = ADJ_NONE;
		cmd.dst    = DST_NONE;
		cmd.set_nz = 1'b1;
		cmd.addr   = tdata[OP_W +: ADDR_W];
		cmd.rd     = tdata[OP_W + ADDR_W +: DATA_W];
		case (op)
			OP_DEC: begin cmd.adj = ADJ_DEC; cmd.dst = DST_MEM; end
			OP_DEX: begin cmd.src = SRC_X; cmd.adj = ADJ_DEC; cmd.dst = DST_X; end
			OP_DEY: begin cmd.src = SRC_Y; cmd.adj = ADJ_DEC; cmd.dst = DST_Y; end
			OP_INC: begin cmd.adj = ADJ_INC; cmd.dst = DST_MEM; end
			OP_INX: begin cmd.src = SRC_X; cmd.adj = ADJ_INC; cmd.dst = DST_X; end
			OP_INY: begin cmd.src = SRC_Y; cmd.adj = ADJ_INC; cmd.dst = DST_Y; end
			OP_LDA: begin cmd.dst = DST_ACC; end
			OP_LDX: begin cmd.dst = DST_X; end
			OP_LDY: begin cmd.dst = DST_Y; end
			OP_STA: begin cmd.src = SRC_ACC; cmd.dst = DST_MEM; cmd.set_nz = 1'b0; end
			OP_STX: begin cmd.src = SRC_X; cmd.dst = DST_MEM; cmd.set_nz = 1'b0; end
			OP_STY: begin cmd.src = SRC_Y; cmd.dst = DST_MEM; cmd.set_nz = 1'b0; end
			OP_TAX: begin cmd.src = SRC_ACC; cmd.dst = DST_X; end
			OP_TAY: begin cmd.src = SRC_ACC; cmd.dst = DST_Y; end
			OP_TSX: begin cmd.src = SRC_SP; cmd.dst = DST_X; end
			OP_TXA: begin cmd.src = SRC_X; cmd.dst = DST_ACC; end
			OP_TXS: begin cmd.src = SRC_X; cmd.dst = DST_SP; cmd.set_nz = 1'b0; end
			OP_TYA: begin cmd.src = SRC_Y; cmd.dst = DST_ACC; end
			default: begin cmd.set_nz = 1'b0; end
		endcase
	end

endmodule

[design/lsx_back.sv]
`timescale 1ns / 1ps
module lsx_back import lsx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_stat_t q_stat,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       tvalid,
	input  logic       tready,
	output res_t       res
);

	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] sp_q;
	logic              z_q;
	logic              n_q;
	logic              valid_q;
	res_t              res_q;
	logic [DATA_W-1:0] src_val;
	logic [DATA_W-1:0] val;
	res_t              nxt;

	assign pop    = !q_stat.empty && (!valid_q || tready);
	assign tvalid = valid_q;
	assign res    = res_q;

	always_comb begin
		case (head_cmd.src)
			SRC_MEM: src_val = head_cmd.rd;
			SRC_ACC: src_val = acc_q;
			SRC_X:   src_val = x_q;
			SRC_Y:   src_val = y_q;
			SRC_SP:  src_val = sp_q;
			default: src_val = '0;
		endcase
		case (head_cmd.adj)
			ADJ_INC: val = src_val + DATA_W'(1);
			ADJ_DEC: val = src_val - DATA_W'(1);
			default: val = src_val;
		endcase
		nxt.we   = (head_cmd.dst == DST_MEM);
		nxt.addr = head_cmd.addr;
		nxt.wd   = nxt.we ? val : '0;
		nxt.acc  = (head_cmd.dst == DST_ACC) ? val : acc_q;
		nxt.x    = (head_cmd.dst == DST_X) ? val : x_q;
		nxt.y    = (head_cmd.dst == DST_Y) ? val : y_q;
		nxt.sp   = (head_cmd.dst == DST_SP) ? val : sp_q;
		nxt.z    = head_cmd.set_nz ? (val == '0) : z_q;
		nxt.n    = head_cmd.set_nz ? val[DATA_W-1] : n_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			sp_q    <= '0;
			z_q     <= 1'b0;
			n_q     <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q   <= nxt.acc;
				x_q     <= nxt.x;
				y_q     <= nxt.y;
				sp_q    <= nxt.sp;
				z_q     <= nxt.z;
				n_q     <= nxt.n;
				valid_q <= 1'b1;
			end else if (tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/cpu_load_store_transfer_exec_unit.sv]
`timescale 1ns / 1ps
// An instruction beat is written into the command queue, then taken into the result register,
// from which it is offered on the output.
// Throughput: one instruction per cycle while the output is not stalled; the back end updates its registers as it pops.
// The command queue (QUEUE_DEPTH entries) absorbs output stalls until it fills, then holds the input.
// Reset (arst_n low, asynchronous) clears A, X, Y, SP, both flags, the queue and the output valid.
`include "assert_macros.svh"
module cpu_load_store_transfer_exec_unit import lsx_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0 up: req_type[4:0], operand_address[20:5], mem_read_data[28:21],
	// zero fill [31:29].
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0 up: mem_write_enable[0], mem_write_address[16:1],
	// mem_write_data[24:17], acc_out[32:25], x_out[40:33], y_out[48:41],
	// sp_out[56:49], zero_out[57], negative_out[58], zero fill [63:59].
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// The front end only decodes; all architectural state lives in the back end,
	// so an instruction sitting in the queue never reads stale registers.
	fifo_stat_t q_stat;
	cmd_t       push_cmd;
	cmd_t       head_cmd;
	logic       push;
	logic       pop;
	res_t       res;

	lsx_front u_front (
		.tvalid (s_axis_tvalid),
		.tready (s_axis_tready),
		.tdata  (s_axis_tdata),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	lsx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	// The back end pops whenever the queue holds an entry and its result register is free or being drained.
	// While a result waits on the output, new beats still enter until the queue is full.
	lsx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_cmd (head_cmd),
		.pop      (pop),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {
		(OUT_TDATA_W - 59)'(0),
		res.n, res.z, res.sp, res.y, res.x, res.acc, res.wd, res.addr, res.we
	};

	// The queue is never read while empty.
	`LSX_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty)
	// The queue can not report full and empty at once.
	`LSX_ASSERT(a_full_empty, !(q_stat.full && q_stat.empty))
	// A beat without a memory write carries zero write data.
	`LSX_ASSERT(a_wd_zero, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:17] == 8'd0))
	// A beat accepted into an empty queue with a free output is popped by the back end in the cycle after.
	`LSX_ASSERT(a_lat, (push && q_stat.empty && !m_axis_tvalid) |=> pop)

endmodule
